FILE: src/gsw_pkg.sv
// Shared types, constants and the Gaussian weight table for the window filter.
package gsw_pkg;

  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxHeightDef = 2048;
  localparam int unsigned RawLines     = 8;
  localparam int unsigned LineBits     = 3;
  localparam int unsigned JobDepth     = 4;
  localparam int unsigned ResDepth     = 2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic [1:0] MODE_COPY = 2'd0;
  localparam logic [1:0] MODE_BLUR = 2'd1;
  localparam logic [1:0] MODE_EDGE = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic [1:0]          FilterModeRst  = MODE_BLUR;
  localparam logic [CfgDataW-1:0] FrameWidthRst  = 12'd640;
  localparam logic [CfgDataW-1:0] FrameHeightRst = 12'd480;

  // Floor divide by 273 as multiply by 122911 and shift by 25; exact for sums
  // up to 273*255.
  localparam int unsigned AccW       = 17;
  localparam int unsigned RecipW     = 17;
  localparam int unsigned RecipShift = 25;
  localparam logic [RecipW-1:0] GaussRecip = 17'd122911;

  localparam int unsigned PixW = 24;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       last_pixel;
  } pix_out_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_FLUSH,
    B_DIV,
    B_SUM,
    B_OUT
  } back_state_e;

  // 5x5 kernel 1 4 7 4 1 / 4 16 26 16 4 / 7 26 41 26 7, symmetric about the center.
  function automatic logic [5:0] gauss_weight(input logic [2:0] s, input logic [2:0] t);
    logic [1:0] ds;
    logic [1:0] dt;
    logic [1:0] lo;
    logic [1:0] hi;
    logic [5:0] w;
    ds = (s >= 3'd2) ? 2'(s - 3'd2) : 2'(3'd2 - s);
    dt = (t >= 3'd2) ? 2'(t - 3'd2) : 2'(3'd2 - t);
    lo = (ds < dt) ? ds : dt;
    hi = (ds < dt) ? dt : ds;
    case ({lo, hi})
      4'b0000: w = 6'd41;
      4'b0001: w = 6'd26;
      4'b0010: w = 6'd7;
      4'b0101: w = 6'd16;
      4'b0110: w = 6'd4;
      default: w = 6'd1;
    endcase
    return w;
  endfunction

endpackage

FILE: src/gauss_sobel_window_filter_top.sv
// Top level of the streaming Gaussian blur / Sobel edge window filter.
// Pixels arrive in raster order and are written into an eight-line raw store;
// the front part takes one item per clock, decides when the next output position
// has all of its neighbors and queues a job for it. The back part works each job
// through the single read port of the raw line RAM, one window tap per cycle, with
// a shared multiply-accumulate and a reciprocal multiply for the divide by 273.
// Copy mode reads one tap per result, blur mode a 5x5 window and edge mode the
// windows of nine blurred neighbors, so that read port sets the sustained output
// rate; input is taken back to back until the four-entry job
// queue fills, or while a new pixel would overwrite a line still needed by the
// oldest unfinished job or a new frame would begin before the previous frame's
// jobs are done. Results wait in a two-entry queue. Drain items release pending
// outputs at the end of a frame. The raw store needs no clearing after reset.
module gauss_sobel_window_filter_top #(
  parameter int unsigned MaxWidth  = gsw_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = gsw_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input queue side
  input  logic                          push,
  input  gsw_pkg::pix_in_t              in_item_i,
  output logic                          full,
  // result queue side
  output logic                          empty,
  input  logic                          pop,
  output gsw_pkg::pix_out_t             out_item_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gsw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gsw_pkg::CfgDataW-1:0]  cfg_data_i
);
  import gsw_pkg::*;

  localparam int unsigned CW   = $clog2(MaxWidth) + 1;
  localparam int unsigned RW   = $clog2(MaxHeight) + 1;
  localparam int unsigned AW   = LineBits + $clog2(MaxWidth);
  localparam int unsigned JobW = RW + CW + 2;
  localparam int unsigned ResW = $bits(pix_out_t);

  logic [1:0]          mode_q;
  logic [CfgDataW-1:0] width_q, height_q;
  logic [31:0]         w_raw, h_raw, w_clip, h_clip;
  logic [CW-1:0]       width_eff;
  logic [RW-1:0]       height_eff;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [PixW-1:0] ram_wdata, ram_rdata;

  logic            job_push, job_full, job_pop, job_empty;
  logic [JobW-1:0] job_in, job_head;

  logic            back_busy, back_epoch;
  logic [RW-1:0]   back_row;
  logic            pend_vld, pend_epoch;
  logic [RW-1:0]   pend_row;

  logic            res_push, res_full;
  pix_out_t        res_item;
  logic [ResW-1:0] res_head;

  // Configuration is taken every cycle; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= FilterModeRst;
      width_q  <= FrameWidthRst;
      height_q <= FrameHeightRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FILTER_MODE:  mode_q   <= cfg_data_i[1:0];
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Clamp sizes to one up to the line store limits.
  always_comb begin
    w_raw  = 32'(width_q);
    h_raw  = 32'(height_q);
    w_clip = (w_raw == '0) ? 32'd1 : ((w_raw > 32'(MaxWidth)) ? 32'(MaxWidth) : w_raw);
    h_clip = (h_raw == '0) ? 32'd1 : ((h_raw > 32'(MaxHeight)) ? 32'(MaxHeight) : h_raw);
    width_eff  = CW'(w_clip);
    height_eff = RW'(h_clip);
  end

  // The oldest unfinished job: the one in the back part, else the queue head.
  assign pend_vld   = back_busy | ~job_empty;
  assign pend_row   = back_busy ? back_row : job_head[CW +: RW];
  assign pend_epoch = back_busy ? back_epoch : job_head[JobW-1];

  gsw_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (in_item_i),
    .full_o       (full),
    .mode_i       (mode_q),
    .width_i      (width_eff),
    .height_i     (height_eff),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .pend_vld_i   (pend_vld),
    .pend_row_i   (pend_row),
    .pend_epoch_i (pend_epoch),
    .job_full_i   (job_full),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  gsw_ram #(
    .Width (PixW),
    .Depth (RawLines * MaxWidth)
  ) u_raw_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gsw_fifo #(
    .Width (JobW),
    .Depth (JobDepth)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_head),
    .empty_o (job_empty)
  );

  gsw_back #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .job_empty_i (job_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .busy_o      (back_busy),
    .row_o       (back_row),
    .epoch_o     (back_epoch),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_item)
  );

  gsw_fifo #(
    .Width (ResW),
    .Depth (ResDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign out_item_o = pix_out_t'(res_head);

`ifndef SYNTHESIS
  a_job_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !back_busy)
    else $error("job taken while another is running");
  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");
  a_write_not_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> push && !full)
    else $error("line write without an accepted item");
`endif

endmodule

FILE: src/gsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gsw_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/gsw_fifo.sv
// Small register queue with first-word fall-through read.
module gsw_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = do_push ? ((wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? ((rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: src/gsw_front.sv
// Input side: position counters, raw line writes, release decision and job issue.
module gsw_front #(
  parameter int unsigned MaxWidth  = gsw_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = gsw_pkg::MaxHeightDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  gsw_pkg::pix_in_t                      item_i,
  output logic                                  full_o,
  input  logic [1:0]                            mode_i,
  input  logic [$clog2(MaxWidth):0]             width_i,
  input  logic [$clog2(MaxHeight):0]            height_i,
  output logic                                  ram_we_o,
  output logic [gsw_pkg::LineBits+$clog2(MaxWidth)-1:0] ram_waddr_o,
  output logic [gsw_pkg::PixW-1:0]              ram_wdata_o,
  input  logic                                  pend_vld_i,
  input  logic [$clog2(MaxHeight):0]            pend_row_i,
  input  logic                                  pend_epoch_i,
  input  logic                                  job_full_i,
  output logic                                  job_push_o,
  output logic [$clog2(MaxHeight)+$clog2(MaxWidth)+3:0] job_o
);
  import gsw_pkg::*;

  localparam int unsigned CW  = $clog2(MaxWidth) + 1;
  localparam int unsigned RW  = $clog2(MaxHeight) + 1;
  localparam int unsigned CAW = $clog2(MaxWidth);

  logic [CW-1:0] ic_q, ic_d, oc_q, oc_d;
  logic [RW-1:0] ir_q, ir_d, or_q, or_d;
  logic          ep_q, ep_d;

  logic [CW-1:0] n_ic, n_oc, w_ic, e_oc, tc;
  logic [RW-1:0] n_ir, n_or, w_ir, e_or, tr;
  logic          n_ep;
  logic [1:0]    k;
  logic          hazard, accept, is_pix, drop, ready, emit, last;

  always_comb begin
    // Normalize: wrap columns, hold the input row at the height, close a finished frame.
    n_ic = ic_q;
    n_ir = ir_q;
    n_oc = oc_q;
    n_or = or_q;
    n_ep = ep_q;
    if (n_ic >= width_i) begin
      n_ic = '0;
      n_ir = n_ir + 1'b1;
    end
    if (n_ir > height_i) begin
      n_ir = height_i;
    end
    if (n_oc >= width_i) begin
      n_oc = '0;
      n_or = n_or + 1'b1;
    end
    if (n_or >= height_i) begin
      n_ic = '0;
      n_ir = '0;
      n_oc = '0;
      n_or = '0;
      n_ep = ~ep_q;
    end

    // Stall while the oldest pending job may still read the line this write reuses.
    hazard = pend_vld_i &&
             ((pend_epoch_i != n_ep) ||
              ({1'b0, n_ir} >= ({1'b0, pend_row_i} + (RW+1)'(5))));
    full_o = job_full_i | hazard;
    accept = push_i & ~full_o;

    is_pix = (item_i.item_kind == KIND_PIXEL);
    drop   = is_pix && (n_ir >= height_i);

    w_ic = n_ic;
    w_ir = n_ir;
    if (is_pix && !drop) begin
      w_ic = n_ic + 1'b1;
      if (w_ic >= width_i) begin
        w_ic = '0;
        w_ir = n_ir + 1'b1;
      end
    end

    k = (mode_i == MODE_COPY) ? 2'd0 : ((mode_i == MODE_BLUR) ? 2'd2 : 2'd3);
    tr = n_or + RW'(k);
    tc = n_oc + CW'(k);
    if (tc > width_i - 1'b1) begin
      tc = width_i - 1'b1;
    end
    ready = (w_ir >= height_i) || (w_ir > tr) || ((w_ir == tr) && (w_ic > tc));
    emit  = accept && !drop && ready;
    last  = (n_or == height_i - 1'b1) && (n_oc == width_i - 1'b1);

    ic_d = w_ic;
    ir_d = w_ir;
    oc_d = n_oc;
    or_d = n_or;
    ep_d = n_ep;
    if (emit) begin
      e_oc = n_oc + 1'b1;
      e_or = n_or;
      if (e_oc >= width_i) begin
        e_oc = '0;
        e_or = n_or + 1'b1;
      end
      oc_d = e_oc;
      or_d = e_or;
      if (e_or >= height_i) begin
        ic_d = '0;
        ir_d = '0;
        oc_d = '0;
        or_d = '0;
        ep_d = ~n_ep;
      end
    end else begin
      e_oc = n_oc;
      e_or = n_or;
    end
  end

  assign ram_we_o    = accept && is_pix && !drop;
  assign ram_waddr_o = {n_ir[LineBits-1:0], n_ic[CAW-1:0]};
  assign ram_wdata_o = {item_i.blue_in, item_i.green_in, item_i.red_in};
  assign job_push_o  = emit;
  assign job_o       = {n_ep, last, n_or, n_oc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q <= '0;
      ir_q <= '0;
      oc_q <= '0;
      or_q <= '0;
      ep_q <= 1'b0;
    end else if (accept) begin
      ic_q <= ic_d;
      ir_q <= ir_d;
      oc_q <= oc_d;
      or_q <= or_d;
      ep_q <= ep_d;
    end
  end

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o |-> !job_full_i && !hazard)
    else $error("job issued without queue room");
  a_write_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (n_ic < width_i) && push_i)
    else $error("line write outside the row");
  a_no_job_on_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && drop) |-> !job_push_o && !ram_we_o)
    else $error("dropped pixel produced work");
`endif

endmodule

FILE: src/gsw_back.sv
// Output side: runs one job at a time over the raw line store with a shared MAC.
module gsw_back #(
  parameter int unsigned MaxWidth  = gsw_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = gsw_pkg::MaxHeightDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [1:0]                            mode_i,
  input  logic [$clog2(MaxWidth):0]             width_i,
  input  logic [$clog2(MaxHeight):0]            height_i,
  input  logic                                  job_empty_i,
  input  logic [$clog2(MaxHeight)+$clog2(MaxWidth)+3:0] job_i,
  output logic                                  job_pop_o,
  output logic [gsw_pkg::LineBits+$clog2(MaxWidth)-1:0] ram_raddr_o,
  input  logic [gsw_pkg::PixW-1:0]              ram_rdata_i,
  output logic                                  busy_o,
  output logic [$clog2(MaxHeight):0]            row_o,
  output logic                                  epoch_o,
  input  logic                                  res_full_i,
  output logic                                  res_push_o,
  output gsw_pkg::pix_out_t                     res_o
);
  import gsw_pkg::*;

  localparam int unsigned CW  = $clog2(MaxWidth) + 1;
  localparam int unsigned RW  = $clog2(MaxHeight) + 1;
  localparam int unsigned CAW = $clog2(MaxWidth);
  localparam int unsigned SRW = RW + 2;
  localparam int unsigned SCW = CW + 2;
  localparam int unsigned GW  = 11;
  localparam int unsigned PW  = AccW + RecipW;

  back_state_e state_q, state_d;

  logic [RW-1:0] jrow_q;
  logic [CW-1:0] jcol_q;
  logic          jlast_q, jep_q;
  logic [1:0]    nbr_a_q, nbr_b_q;
  logic [2:0]    tap_s_q, tap_t_q;
  logic          tap_vld_q;
  logic [5:0]    tap_w_q;
  logic [AccW-1:0]  acc_q [3];
  logic [PW-1:0]    prod_q [3];
  logic signed [GW-1:0] gx_q [3];
  logic signed [GW-1:0] gy_q [3];

  logic is_copy, is_blur;
  logic signed [SRW-1:0] crow, trow, off_r;
  logic signed [SCW-1:0] ccol, tcol, off_c;
  logic center_in, tap_in, tap_ok, last_tap, last_nbr;
  logic [2:0] s_start;
  logic [7:0] blur [3];
  logic [7:0] val [3];
  logic [13:0] mac [3];
  logic [4:0] eighth [3];
  logic [5:0] quarter [3];
  logic signed [GW-1:0] ax [3];
  logic signed [GW-1:0] ay [3];
  logic [GW:0] mag [3];

  assign is_copy = (mode_i == MODE_COPY);
  assign is_blur = (mode_i == MODE_BLUR);

  always_comb begin
    off_r = '0;
    off_c = '0;
    if (!is_copy && !is_blur) begin
      off_r = $signed({{(SRW-2){1'b0}}, nbr_a_q}) - $signed(SRW'(1));
      off_c = $signed({{(SCW-2){1'b0}}, nbr_b_q}) - $signed(SCW'(1));
    end
    crow = $signed({2'b00, jrow_q}) + off_r;
    ccol = $signed({2'b00, jcol_q}) + off_c;
    trow = crow + $signed({{(SRW-3){1'b0}}, tap_s_q}) - $signed(SRW'(2));
    tcol = ccol + $signed({{(SCW-3){1'b0}}, tap_t_q}) - $signed(SCW'(2));
    center_in = (crow >= 0) && (crow < $signed({2'b00, height_i})) &&
                (ccol >= 0) && (ccol < $signed({2'b00, width_i}));
    tap_in    = (trow >= 0) && (trow < $signed({2'b00, height_i})) &&
                (tcol >= 0) && (tcol < $signed({2'b00, width_i}));
    tap_ok    = center_in && tap_in;
    last_tap  = is_copy || ((tap_s_q == 3'd4) && (tap_t_q == 3'd4));
    last_nbr  = (nbr_a_q == 2'd2) && (nbr_b_q == 2'd2);
    s_start   = is_copy ? 3'd2 : 3'd0;
  end

  assign ram_raddr_o = {trow[LineBits-1:0], tcol[CAW-1:0]};

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mac[ch]     = tap_w_q * ram_rdata_i[PixW-1-8*ch -: 8];
      blur[ch]    = prod_q[ch][RecipShift +: 8];
      eighth[ch]  = blur[ch][7:3];
      quarter[ch] = blur[ch][7:2];
      ax[ch]      = gx_q[ch][GW-1] ? -gx_q[ch] : gx_q[ch];
      ay[ch]      = gy_q[ch][GW-1] ? -gy_q[ch] : gy_q[ch];
      mag[ch]     = {1'b0, ax[ch]} + {1'b0, ay[ch]};
      if (is_copy) begin
        val[ch] = acc_q[ch][7:0];
      end else if (is_blur) begin
        val[ch] = blur[ch];
      end else begin
        val[ch] = mag[ch][7:0];
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          state_d   = B_READ;
        end
      end
      B_READ: begin
        if (last_tap) begin
          state_d = B_FLUSH;
        end
      end
      B_FLUSH: begin
        state_d = is_copy ? B_OUT : B_DIV;
      end
      B_DIV: begin
        state_d = B_SUM;
      end
      B_SUM: begin
        state_d = (is_blur || last_nbr) ? B_OUT : B_READ;
      end
      B_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      tap_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tap_vld_q <= (state_q == B_READ) && tap_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    tap_w_q <= is_copy ? 6'd1 : gauss_weight(tap_s_q, tap_t_q);
    for (int ch = 0; ch < 3; ch++) begin
      if (tap_vld_q) begin
        acc_q[ch] <= acc_q[ch] + AccW'(mac[ch]);
      end
      prod_q[ch] <= acc_q[ch] * GaussRecip;
    end
    unique case (state_q)
      B_IDLE: begin
        {jep_q, jlast_q, jrow_q, jcol_q} <= job_i;
        nbr_a_q <= '0;
        nbr_b_q <= '0;
        tap_s_q <= s_start;
        tap_t_q <= s_start;
        for (int ch = 0; ch < 3; ch++) begin
          acc_q[ch] <= '0;
          gx_q[ch]  <= '0;
          gy_q[ch]  <= '0;
        end
      end
      B_READ: begin
        // Advance over the 5x5 window in raster order.
        if (tap_t_q == 3'd4) begin
          tap_t_q <= '0;
          tap_s_q <= tap_s_q + 1'b1;
        end else begin
          tap_t_q <= tap_t_q + 1'b1;
        end
      end
      B_SUM: begin
        for (int ch = 0; ch < 3; ch++) begin
          // Hold the blur sum so the quotient survives a stalled output.
          if (!is_blur) begin
            acc_q[ch] <= '0;
          end
          if (nbr_a_q != 2'd1) begin
            if (nbr_a_q == 2'd0) begin
              gx_q[ch] <= gx_q[ch] + ((nbr_b_q == 2'd1) ? $signed(GW'(quarter[ch]))
                                                        : $signed(GW'(eighth[ch])));
            end else begin
              gx_q[ch] <= gx_q[ch] - ((nbr_b_q == 2'd1) ? $signed(GW'(quarter[ch]))
                                                        : $signed(GW'(eighth[ch])));
            end
          end
          if (nbr_b_q != 2'd1) begin
            if (nbr_b_q == 2'd2) begin
              gy_q[ch] <= gy_q[ch] + ((nbr_a_q == 2'd1) ? $signed(GW'(quarter[ch]))
                                                        : $signed(GW'(eighth[ch])));
            end else begin
              gy_q[ch] <= gy_q[ch] - ((nbr_a_q == 2'd1) ? $signed(GW'(quarter[ch]))
                                                        : $signed(GW'(eighth[ch])));
            end
          end
        end
        tap_s_q <= '0;
        tap_t_q <= '0;
        if (nbr_b_q == 2'd2) begin
          nbr_b_q <= '0;
          nbr_a_q <= nbr_a_q + 1'b1;
        end else begin
          nbr_b_q <= nbr_b_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy_o  = (state_q != B_IDLE);
  assign row_o   = jrow_q;
  assign epoch_o = jep_q;

  assign res_o.blue_out   = val[0];
  assign res_o.green_out  = val[1];
  assign res_o.red_out    = val[2];
  assign res_o.last_pixel = jlast_q;

`ifndef SYNTHESIS
  a_tap_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_vld_q |-> $past(state_q == B_READ))
    else $error("tap valid outside a read sweep");
  a_pop_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (state_q == B_READ) && !tap_vld_q)
    else $error("job pop did not start a sweep");
  a_push_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (state_q == B_IDLE))
    else $error("result pushed but job not retired");
`endif

endmodule
